// ===== sv/pfc_pkg.sv =====
// Package for the pixel format converter: formats, payload structs, luma constants.
// Used by pfc_luma and pixel_format_converter_core; depends on nothing.
package pfc_pkg;

	typedef enum logic [1:0] {
		FMT_GRAY8   = 2'd0,
		FMT_GRAY16  = 2'd1,
		FMT_SGRAY16 = 2'd2,
		FMT_RGB24   = 2'd3
	} fmt_e_t;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_UNSUP = 2'd1,
		MODE_LUMA  = 2'd2,
		MODE_GRAY  = 2'd3
	} mode_e_t;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 1'b1;

	// BT.709 luma weights, scaled by 10000.
	localparam int W_RED   = 2126;
	localparam int W_GREEN = 7152;
	localparam int W_BLUE  = 722;

	// Division by 10000 as a multiply by ceil(2^36 / 10000) and a shift. The
	// rounding error times the largest weighted sum stays below 2^36, so the
	// quotient is exact.
	localparam int PROD_W   = 21;
	localparam int SUM_W    = 22;
	localparam int RECIP_W  = 23;
	localparam int QPROD_W  = SUM_W + RECIP_W;
	localparam int RECIP_SH = 36;
	localparam logic [RECIP_W-1:0] RECIP = 23'd6871948;

	typedef struct packed {
		logic [15:0] sample_or_red;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [15:0] out_sample_or_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic        status;
	} pixel_out_t;

	// Load enables for the three arithmetic stages.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} stage_ld_t;

endpackage

// ===== sv/pixel_format_converter_core.sv =====
// Top level of the pixel format converter: configuration, pipeline control, output stage.
// Depends on pfc_pkg and pfc_luma.
//
// Converts one pixel per transfer between gray8, gray16, signed gray16 and rgb24,
// as selected by the source and target format registers; a conversion into rgb24 from
// another format is flagged unsupported. The block takes one pixel every clock while
// in_stall is low; each pixel passes through the three luma arithmetic stages and the
// output register. Stages advance on their own, so bubbles close up and the block keeps
// taking pixels while a result waits, until the earlier stages fill. Format registers
// are sampled per pixel at input and should only be written while the pipeline is empty.
module pixel_format_converter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pfc_pkg::pixel_in_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pfc_pkg::pixel_out_t              out_data
);
	import pfc_pkg::*;

	typedef struct packed {
		mode_e_t            mode;
		fmt_e_t             dst;
		logic signed [16:0] val;
		logic [7:0]         green;
		logic [7:0]         blue;
	} ctrl_t;

	fmt_e_t source_format_q, target_format_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	stage_ld_t ld;
	ctrl_t ctrl_in, ctrl_s1, ctrl_s2, ctrl_s3;
	mode_e_t mode_s4;
	logic [7:0] luma;
	pixel_out_t out_next;

	function automatic logic signed [16:0] gray_value(fmt_e_t fmt, logic [15:0] raw);
		case (fmt)
			FMT_GRAY8:   gray_value = {9'd0, raw[7:0]};
			FMT_GRAY16:  gray_value = {1'b0, raw};
			default:     gray_value = {raw[15], raw};
		endcase
	endfunction

	function automatic logic [15:0] gray_pack(fmt_e_t fmt, logic signed [16:0] v);
		logic [15:0] r;
		r = v[15:0];
		case (fmt)
			FMT_GRAY8: begin
				if (v < 0)
					r = 16'd0;
				else if (v > 17'sd255)
					r = 16'd255;
			end
			FMT_GRAY16: begin
				if (v < 0)
					r = 16'd0;
			end
			default: begin
				if (v > 17'sd32767)
					r = 16'h7fff;
				else if (v < -17'sd32768)
					r = 16'h8000;
			end
		endcase
		gray_pack = r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_GRAY8;
			target_format_q <= FMT_GRAY8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_FORMAT: source_format_q <= fmt_e_t'(cfg_wdata);
				CFG_TARGET_FORMAT: target_format_q <= fmt_e_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Each stage takes new data when it is empty or its contents move on.
	assign rdy4 = !v4_s4 || !out_stall;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	assign ld.ld_s1 = rdy1 && in_valid;
	assign ld.ld_s2 = rdy2 && v1_s1;
	assign ld.ld_s3 = rdy3 && v2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	always_comb begin
		ctrl_in.dst   = target_format_q;
		ctrl_in.val   = gray_value(source_format_q, in_data.sample_or_red);
		ctrl_in.green = 8'd0;
		ctrl_in.blue  = 8'd0;
		if (source_format_q == target_format_q) begin
			ctrl_in.mode = MODE_PASS;
			if (source_format_q == FMT_RGB24) begin
				ctrl_in.val   = {9'd0, in_data.sample_or_red[7:0]};
				ctrl_in.green = in_data.green_in;
				ctrl_in.blue  = in_data.blue_in;
			end
		end else if (target_format_q == FMT_RGB24) begin
			ctrl_in.mode = MODE_UNSUP;
		end else if (source_format_q == FMT_RGB24) begin
			ctrl_in.mode = MODE_LUMA;
		end else begin
			ctrl_in.mode = MODE_GRAY;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s1) ctrl_s1 <= ctrl_in;
		if (ld.ld_s2) ctrl_s2 <= ctrl_s1;
		if (ld.ld_s3) ctrl_s3 <= ctrl_s2;
	end

	pfc_luma u_luma (
		.clk   (clk),
		.ld    (ld),
		.red   (in_data.sample_or_red[7:0]),
		.green (in_data.green_in),
		.blue  (in_data.blue_in),
		.luma  (luma)
	);

	always_comb begin
		out_next = '0;
		case (ctrl_s3.mode)
			MODE_PASS: begin
				out_next.out_sample_or_red = ctrl_s3.val[15:0];
				out_next.out_green         = ctrl_s3.green;
				out_next.out_blue          = ctrl_s3.blue;
			end
			MODE_UNSUP: out_next.status = 1'b1;
			MODE_LUMA:  out_next.out_sample_or_red = {8'd0, luma};
			MODE_GRAY:  out_next.out_sample_or_red = gray_pack(ctrl_s3.dst, ctrl_s3.val);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v3_s3) begin
			out_data <= out_next;
			mode_s4  <= ctrl_s3.mode;
		end
	end

	assign out_valid = v4_s4;

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |->
			out_data.out_sample_or_red == 16'd0 && out_data.out_green == 8'd0 &&
			out_data.out_blue == 8'd0)
		else $error("unsupported result carries nonzero pixel data");

	a_luma_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_s4 == MODE_LUMA |->
			out_data.out_sample_or_red[15:8] == 8'd0 && !out_data.status)
		else $error("luma result exceeds a byte or flags unsupported");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> !in_stall)
		else $error("input stalled while first stage is empty");

	a_transfer_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v1_s1)
		else $error("accepted transfer did not reach the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 && v4_s4 && out_stall |=> v3_s3 && v4_s4)
		else $error("stalled pipeline dropped an item");

endmodule

// ===== sv/pfc_luma.sv =====
// Three-stage luma datapath: weighted products, their sum, reciprocal multiply.
// Depends on pfc_pkg; stage loads come from the pipeline control in the top level.
module pfc_luma (
	input  logic             clk,
	input  pfc_pkg::stage_ld_t ld,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	output logic [7:0]       luma
);
	import pfc_pkg::*;

	logic [PROD_W-1:0]  prod_r_s1, prod_g_s1, prod_b_s1;
	logic [SUM_W-1:0]   sum_s2;
	logic [QPROD_W-1:0] quot_s3;

	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			prod_r_s1 <= PROD_W'(red)   * PROD_W'(W_RED);
			prod_g_s1 <= PROD_W'(green) * PROD_W'(W_GREEN);
			prod_b_s1 <= PROD_W'(blue)  * PROD_W'(W_BLUE);
		end
		if (ld.ld_s2) begin
			sum_s2 <= SUM_W'(prod_r_s1) + SUM_W'(prod_g_s1) + SUM_W'(prod_b_s1);
		end
		if (ld.ld_s3) begin
			quot_s3 <= QPROD_W'(sum_s2) * QPROD_W'(RECIP);
		end
	end

	// The weighted sum never exceeds 255 * 10000, so the quotient fits a byte.
	assign luma = quot_s3[RECIP_SH+7:RECIP_SH];

endmodule
